// ----- rtl/wrn_pkg.sv -----
// shared types and constants of the weighted rms norm core
package wrn_pkg;

  localparam int unsigned COUNT_W = 21;

  typedef struct packed {
    logic signed [31:0] elem_value;
    logic signed [31:0] elem_weight;
    logic signed [31:0] mask_value;
    logic               last_elem;
  } wrn_in_t;

  typedef struct packed {
    logic [31:0]        norm_result;
    logic [COUNT_W-1:0] element_total;
    logic               saturated;
  } wrn_out_t;

  // classified element as held in the queue between front and back
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] weight;
    logic               take;
    logic               last;
  } wrn_q_t;

  // queue handshake seen by the back end
  typedef struct packed {
    logic   valid;
    wrn_q_t item;
  } wrn_qhead_t;

endpackage

// ----- rtl/wrn_front.sv -----
// front end: accepts elements, applies the mask test and queues them
module wrn_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            mask_enable,
  input  logic            push,
  output logic            full,
  input  wrn_pkg::wrn_in_t item,
  output wrn_pkg::wrn_qhead_t head,
  input  logic            q_pop
);
  import wrn_pkg::*;

  localparam int unsigned DEPTH = 4;

  wrn_q_t     mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       do_push;
  logic       do_pop;
  wrn_q_t     cls;

  assign full    = (fill == 3'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = q_pop && (fill != 3'd0);

  always_comb begin
    cls.value  = item.elem_value;
    cls.weight = item.elem_weight;
    cls.take   = !mask_enable || (item.mask_value > 32'sd0);
    cls.last   = item.last_elem;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(do_push) - 3'(do_pop);
    end
  end

  assign head.valid = (fill != 3'd0);
  assign head.item  = mem[rd_ptr];

endmodule

// ----- rtl/wrn_back.sv -----
// back end: multiply, square, accumulate, divide and root sequencer
module wrn_back #(
  parameter int unsigned COUNT_CAP = 1048576
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               norm_mode,
  input  wrn_pkg::wrn_qhead_t head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output wrn_pkg::wrn_out_t  result
);
  import wrn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(COUNT_CAP);

  logic [2:0]         state;
  wrn_q_t             cur;
  logic signed [63:0] prod;
  logic [63:0]        sq;
  logic [63:0]        sum;
  logic [COUNT_W-1:0] cnt;
  logic               sat;
  logic [63:0]        rad;
  logic [COUNT_W-1:0] rem;
  logic [32:0]        srem;
  logic [31:0]        root;
  logic [5:0]         step;
  logic               res_valid;
  wrn_out_t           res;

  logic signed [63:0] prod_w;
  logic               psat;
  logic [31:0]        qs;
  logic [31:0]        mag;
  logic [63:0]        sq_w;
  logic [64:0]        sum_add;
  logic [63:0]        sum_new;
  logic [COUNT_W:0]   dt;
  logic [34:0]        st;
  logic [34:0]        trial;

  assign prod_w = cur.value * cur.weight;
  assign psat   = !((&prod[63:47]) || (~|prod[63:47]));
  assign qs     = psat ? (prod[63] ? 32'h8000_0000 : 32'h7fff_ffff) : prod[47:16];
  assign mag    = qs[31] ? (~qs + 32'd1) : qs;
  assign sq_w   = mag * mag;
  assign sum_add = {1'b0, sum} + {1'b0, sq};
  assign sum_new = !cur.take ? sum : (sum_add[64] ? '1 : sum_add[63:0]);
  assign dt     = {rem, rad[63]};
  assign st     = {srem, rad[63:62]};
  assign trial  = {1'b0, root, 2'b01};

  assign q_pop  = (state == S_IDLE) && head.valid;
  assign empty  = !res_valid;
  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum       <= '0;
      cnt       <= '0;
      sat       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur   <= head.item;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= prod_w;
          state <= S_SQR;
        end
        S_SQR: begin
          sq <= cur.take ? sq_w : '0;
          if (cur.take && psat) sat <= 1'b1;
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum_new;
          if (cnt < CAP) cnt <= cnt + COUNT_W'(1);
          if ((cur.take && sum_add[64]) || (cnt >= CAP)) sat <= 1'b1;
          rad  <= sum_new;
          rem  <= '0;
          srem <= '0;
          root <= '0;
          step <= '0;
          if (!cur.last) state <= S_IDLE;
          else if (!norm_mode) state <= S_DIV;
          else state <= S_SQRT;
        end
        S_DIV: begin
          // restoring divide, one quotient bit a step
          if (dt >= {1'b0, cnt}) begin
            rem <= COUNT_W'(dt - {1'b0, cnt});
            rad <= {rad[62:0], 1'b1};
          end else begin
            rem <= dt[COUNT_W-1:0];
            rad <= {rad[62:0], 1'b0};
          end
          if (step == 6'd63) begin
            step  <= '0;
            state <= S_SQRT;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_SQRT: begin
          // digit by digit root, one result bit a step
          if (st >= trial) begin
            srem <= 33'(st - trial);
            root <= {root[30:0], 1'b1};
          end else begin
            srem <= st[32:0];
            root <= {root[30:0], 1'b0};
          end
          rad  <= {rad[61:0], 2'b00};
          step <= step + 6'd1;
          if (step == 6'd31) state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid) begin
            res.norm_result   <= root;
            res.element_total <= cnt;
            res.saturated     <= sat;
            res_valid         <= 1'b1;
            sum               <= '0;
            cnt               <= '0;
            sat               <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst) cnt <= CAP)
    else $error("element count beyond cap");
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res_valid) |=> (res_valid && state == S_IDLE && cnt == '0))
    else $error("result not loaded on completion");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE))
    else $error("queue popped while busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(res_valid) && !$past(pop)) |-> (res_valid && $stable(res)))
    else $error("waiting result changed");
`endif

endmodule

// ----- rtl/weighted_rms_norm_core.sv -----
// top level of the weighted rms / weighted l2 norm core
// A vector streams in one element per push beat; the front queue (four
// entries) takes elements while the back end works. The back end steps each
// element through queue pop, multiply, square and accumulate, and takes the
// next element from the queue only after the accumulate. On the last element
// it adds 64 restoring-divide steps in rms mode, then 32 root steps and a
// load of the result register, which waits while an earlier result is still
// unread. A finished result waits on the result ports while the next
// vector is already being accumulated.
module weighted_rms_norm_core #(
  parameter int unsigned MAX_LENGTH = 1048576
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_data,
  input  logic              push,
  output logic              full,
  input  wrn_pkg::wrn_in_t  item,
  output logic              empty,
  input  logic              pop,
  output wrn_pkg::wrn_out_t result
);
  import wrn_pkg::*;

  // register indexes
  localparam logic REG_NORM_MODE   = 1'b0;
  localparam logic REG_MASK_ENABLE = 1'b1;

  // count stops at the vector length limit or the field maximum
  localparam int unsigned FIELD_MAX = (1 << COUNT_W) - 1;
  localparam int unsigned COUNT_CAP = (MAX_LENGTH < FIELD_MAX) ? MAX_LENGTH : FIELD_MAX;

  logic       norm_mode;
  logic       mask_enable;
  wrn_qhead_t head;
  logic       q_pop;

  // configuration registers, kept across vectors
  always_ff @(posedge clk) begin
    if (rst) begin
      norm_mode   <= 1'b0;
      mask_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORM_MODE:   norm_mode   <= cfg_data;
        REG_MASK_ENABLE: mask_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: mask classification and element queue
  wrn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .mask_enable (mask_enable),
    .push        (push),
    .full        (full),
    .item        (item),
    .head        (head),
    .q_pop       (q_pop)
  );

  // back: arithmetic sequencer and result register
  wrn_back #(
    .COUNT_CAP (COUNT_CAP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .norm_mode (norm_mode),
    .head      (head),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
